// ===== rtl/hesp_pkg.sv =====
// ----------------------------------------------------------------------------
// hesp_pkg
// shared types and constants of the hunk executable stream parser
// ----------------------------------------------------------------------------
`default_nettype none

package hesp_pkg;

  localparam int unsigned BYTE_COUNT_BITS_DEF  = 48;
  localparam int unsigned EVENT_COUNT_BITS_DEF = 32;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 30;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  localparam logic [LEN_W-1:0] HT_UNIT    = 30'd999;
  localparam logic [LEN_W-1:0] HT_NAME    = 30'd1000;
  localparam logic [LEN_W-1:0] HT_CODE    = 30'd1001;
  localparam logic [LEN_W-1:0] HT_DATA    = 30'd1002;
  localparam logic [LEN_W-1:0] HT_BSS     = 30'd1003;
  localparam logic [LEN_W-1:0] HT_RELOC32 = 30'd1004;
  localparam logic [LEN_W-1:0] HT_SYMBOL  = 30'd1008;
  localparam logic [LEN_W-1:0] HT_DEBUG   = 30'd1009;
  localparam logic [LEN_W-1:0] HT_END     = 30'd1010;
  localparam logic [LEN_W-1:0] HT_HEADER  = 30'd1011;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_HEADER  = 3'd1,
    ST_MALFORMED   = 3'd2,
    ST_BAD_RANGE   = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    PH_HEADER, PH_RESLEN, PH_RESSKIP, PH_TSIZE, PH_FIRST, PH_LAST, PH_TABLE,
    PH_HUNK, PH_CODESIZE, PH_DATASIZE, PH_BSSSIZE, PH_BODYSKIP,
    PH_RELCNT, PH_RELTGT, PH_RELSKIP, PH_SYMLEN, PH_SYMSKIP, PH_SYMVAL,
    PH_AUXSIZE, PH_DBGSIZE
  } phase_e;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic [WORD_W-1:0] word;
  } hesp_req_t;

endpackage

`default_nettype wire

// ===== rtl/hesp_in_if.sv =====
// ----------------------------------------------------------------------------
// hesp_in_if
// request channel carrying file words and the end marker
// ----------------------------------------------------------------------------
`default_nettype none

interface hesp_in_if;

  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] word;

  modport source (output valid, output op, output word, input ready);
  modport sink   (input valid, input op, input word, output ready);

endinterface

`default_nettype wire

// ===== rtl/hesp_out_if.sv =====
// ----------------------------------------------------------------------------
// hesp_out_if
// summary channel, one request per file
// ----------------------------------------------------------------------------
`default_nettype none

interface hesp_out_if import hesp_pkg::*; #(
  parameter int unsigned BYTE_COUNT_BITS  = BYTE_COUNT_BITS_DEF,
  parameter int unsigned EVENT_COUNT_BITS = EVENT_COUNT_BITS_DEF
);

  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [EVENT_COUNT_BITS-1:0] segments;
  logic [BYTE_COUNT_BITS-1:0]  code_size;
  logic [BYTE_COUNT_BITS-1:0]  data_size;
  logic [BYTE_COUNT_BITS-1:0]  bss_size;
  logic [EVENT_COUNT_BITS-1:0] reloc_entries;
  logic [EVENT_COUNT_BITS-1:0] symbol_count;
  logic [EVENT_COUNT_BITS-1:0] debug_count;
  logic [EVENT_COUNT_BITS-1:0] hunk_count;

  modport source (
    output valid, output status, output segments, output code_size,
    output data_size, output bss_size, output reloc_entries,
    output symbol_count, output debug_count, output hunk_count,
    input ready
  );
  modport sink (
    input valid, input status, input segments, input code_size,
    input data_size, input bss_size, input reloc_entries,
    input symbol_count, input debug_count, input hunk_count,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/hesp_in_stage.sv =====
// ----------------------------------------------------------------------------
// hesp_in_stage
// input register in front of the parser core
// ----------------------------------------------------------------------------
`default_nettype none

module hesp_in_stage import hesp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hesp_in_if.sink    in_i,
  input  logic       advance_i,
  output hesp_req_t  req_o
);

  logic              valid_q;
  logic              op_q;
  logic [WORD_W-1:0] word_q;
  logic              load;

  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q   <= in_i.op;
      word_q <= in_i.word;
    end
  end

  assign req_o = '{valid: valid_q, op: op_q, word: word_q};

endmodule

`default_nettype wire

// ===== rtl/hesp_core.sv =====
// ----------------------------------------------------------------------------
// hesp_core
// phase machine, skip counter, range check and saturating totals
// ----------------------------------------------------------------------------
`default_nettype none

module hesp_core import hesp_pkg::*; #(
  parameter int unsigned BYTE_COUNT_BITS  = BYTE_COUNT_BITS_DEF,
  parameter int unsigned EVENT_COUNT_BITS = EVENT_COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hesp_req_t                   req_i,
  input  logic                        out_free_i,
  output logic                        advance_o,
  output logic                        load_o,
  output status_e                     status_o,
  output logic [EVENT_COUNT_BITS-1:0] segments_o,
  output logic [BYTE_COUNT_BITS-1:0]  code_size_o,
  output logic [BYTE_COUNT_BITS-1:0]  data_size_o,
  output logic [BYTE_COUNT_BITS-1:0]  bss_size_o,
  output logic [EVENT_COUNT_BITS-1:0] reloc_entries_o,
  output logic [EVENT_COUNT_BITS-1:0] symbol_count_o,
  output logic [EVENT_COUNT_BITS-1:0] debug_count_o,
  output logic [EVENT_COUNT_BITS-1:0] hunk_count_o
);

  localparam int unsigned BW = BYTE_COUNT_BITS;
  localparam int unsigned EW = EVENT_COUNT_BITS;
  localparam int unsigned SW = ((EW > WORD_W) ? EW : WORD_W) + 1;
  localparam logic [BW-1:0] BYTE_MAX  = '1;
  localparam logic [EW-1:0] EVENT_MAX = '1;

  phase_e            phase_q, phase_d;
  status_e           err_q, err_d;
  logic [LEN_W-1:0]  skip_q, skip_d;
  logic [WORD_W-1:0] tlen_q, tlen_d;
  logic [WORD_W-1:0] first_q, first_d;
  logic [EW-1:0]     seg_q, seg_d;
  logic [BW-1:0]     code_q, code_d;
  logic [BW-1:0]     data_q, data_d;
  logic [BW-1:0]     bss_q, bss_d;
  logic [EW-1:0]     reloc_q, reloc_d;
  logic [EW-1:0]     sym_q, sym_d;
  logic [EW-1:0]     dbg_q, dbg_d;
  logic [EW-1:0]     hunk_q, hunk_d;

  logic              fire;
  logic [LEN_W-1:0]  len;
  logic              too_long;
  logic [WORD_W-1:0] span;
  logic              bad_range;
  logic [BW-1:0]     byte_acc;
  logic [BW:0]       byte_sum;
  logic [BW-1:0]     byte_sat;
  logic [SW-1:0]     reloc_sum;
  logic [EW-1:0]     reloc_sat;

  function automatic logic [EW-1:0] inc_sat(input logic [EW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign advance_o = req_i.valid && (req_i.op == OP_DATA || out_free_i);
  assign load_o    = req_i.valid && req_i.op == OP_EOF && out_free_i;
  assign fire      = advance_o;

  assign len       = req_i.word[LEN_W-1:0];
  assign too_long  = req_i.word[WORD_W-1:LEN_W] != '0;
  assign span      = req_i.word - first_q + 32'd1;
  assign bad_range = (req_i.word < first_q) || (tlen_q == '0) || (span > tlen_q);

  // one shared adder for the three segment byte totals
  assign byte_acc = (phase_q == PH_CODESIZE) ? code_q :
                    (phase_q == PH_DATASIZE) ? data_q : bss_q;
  assign byte_sum = {1'b0, byte_acc} + (BW+1)'({len, 2'b00});
  assign byte_sat = byte_sum[BW] ? BYTE_MAX : byte_sum[BW-1:0];

  assign reloc_sum = SW'(reloc_q) + SW'(req_i.word);
  assign reloc_sat = (reloc_sum > SW'(EVENT_MAX)) ? EVENT_MAX : reloc_sum[EW-1:0];

  // next state
  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    skip_d  = skip_q;
    tlen_d  = tlen_q;
    first_d = first_q;
    seg_d   = seg_q;
    code_d  = code_q;
    data_d  = data_q;
    bss_d   = bss_q;
    reloc_d = reloc_q;
    sym_d   = sym_q;
    dbg_d   = dbg_q;
    hunk_d  = hunk_q;
    if (fire) begin
      if (req_i.op == OP_EOF) begin
        phase_d = PH_HEADER;
        err_d   = ST_OK;
        skip_d  = '0;
        tlen_d  = '0;
        first_d = '0;
        seg_d   = '0;
        code_d  = '0;
        data_d  = '0;
        bss_d   = '0;
        reloc_d = '0;
        sym_d   = '0;
        dbg_d   = '0;
        hunk_d  = '0;
      end else if (err_q == ST_OK) begin
        unique case (phase_q)
          PH_HEADER: begin
            if (len != HT_HEADER) err_d = ST_NOT_HEADER;
            else phase_d = PH_RESLEN;
          end
          PH_RESLEN: begin
            if (req_i.word == '0) phase_d = PH_TSIZE;
            else if (too_long) err_d = ST_MALFORMED;
            else begin
              skip_d  = len;
              phase_d = PH_RESSKIP;
            end
          end
          PH_RESSKIP: begin
            skip_d = skip_q - 1'b1;
            if (skip_q == LEN_W'(1)) phase_d = PH_RESLEN;
          end
          PH_TSIZE: begin
            tlen_d  = req_i.word;
            phase_d = PH_FIRST;
          end
          PH_FIRST: begin
            first_d = req_i.word;
            phase_d = PH_LAST;
          end
          PH_LAST: begin
            if (bad_range) err_d = ST_BAD_RANGE;
            else phase_d = PH_TABLE;
          end
          PH_TABLE: begin
            tlen_d = tlen_q - 1'b1;
            if (tlen_q == WORD_W'(1)) phase_d = PH_HUNK;
          end
          PH_HUNK: begin
            hunk_d = inc_sat(hunk_q);
            priority if (len == HT_CODE) phase_d = PH_CODESIZE;
            else if (len == HT_DATA) phase_d = PH_DATASIZE;
            else if (len == HT_BSS) phase_d = PH_BSSSIZE;
            else if (len == HT_RELOC32) phase_d = PH_RELCNT;
            else if (len == HT_SYMBOL) phase_d = PH_SYMLEN;
            else if (len == HT_DEBUG) phase_d = PH_DBGSIZE;
            else if (len == HT_NAME || len == HT_UNIT) phase_d = PH_AUXSIZE;
            else if (len == HT_END) phase_d = PH_HUNK;
            else err_d = ST_UNSUPPORTED;
          end
          PH_CODESIZE, PH_DATASIZE: begin
            if (phase_q == PH_CODESIZE) code_d = byte_sat;
            else data_d = byte_sat;
            seg_d = inc_sat(seg_q);
            if (len == '0) phase_d = PH_HUNK;
            else begin
              skip_d  = len;
              phase_d = PH_BODYSKIP;
            end
          end
          PH_BSSSIZE: begin
            bss_d   = byte_sat;
            seg_d   = inc_sat(seg_q);
            phase_d = PH_HUNK;
          end
          PH_BODYSKIP: begin
            skip_d = skip_q - 1'b1;
            if (skip_q == LEN_W'(1)) phase_d = PH_HUNK;
          end
          PH_RELCNT: begin
            if (req_i.word == '0) phase_d = PH_HUNK;
            else if (too_long) err_d = ST_MALFORMED;
            else begin
              skip_d  = len;
              reloc_d = reloc_sat;
              phase_d = PH_RELTGT;
            end
          end
          PH_RELTGT: begin
            phase_d = PH_RELSKIP;
          end
          PH_RELSKIP: begin
            skip_d = skip_q - 1'b1;
            if (skip_q == LEN_W'(1)) phase_d = PH_RELCNT;
          end
          PH_SYMLEN: begin
            if (req_i.word == '0) phase_d = PH_HUNK;
            else if (too_long) err_d = ST_MALFORMED;
            else begin
              skip_d  = len;
              phase_d = PH_SYMSKIP;
            end
          end
          PH_SYMSKIP: begin
            skip_d = skip_q - 1'b1;
            if (skip_q == LEN_W'(1)) phase_d = PH_SYMVAL;
          end
          PH_SYMVAL: begin
            sym_d   = inc_sat(sym_q);
            phase_d = PH_SYMLEN;
          end
          PH_DBGSIZE, PH_AUXSIZE: begin
            if (too_long) err_d = ST_MALFORMED;
            else begin
              if (phase_q == PH_DBGSIZE) dbg_d = inc_sat(dbg_q);
              if (len == '0) phase_d = PH_HUNK;
              else begin
                skip_d  = len;
                phase_d = PH_BODYSKIP;
              end
            end
          end
          default: begin
            err_d = ST_MALFORMED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      err_q   <= ST_OK;
      skip_q  <= '0;
      tlen_q  <= '0;
      first_q <= '0;
      seg_q   <= '0;
      code_q  <= '0;
      data_q  <= '0;
      bss_q   <= '0;
      reloc_q <= '0;
      sym_q   <= '0;
      dbg_q   <= '0;
      hunk_q  <= '0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      skip_q  <= skip_d;
      tlen_q  <= tlen_d;
      first_q <= first_d;
      seg_q   <= seg_d;
      code_q  <= code_d;
      data_q  <= data_d;
      bss_q   <= bss_d;
      reloc_q <= reloc_d;
      sym_q   <= sym_d;
      dbg_q   <= dbg_d;
      hunk_q  <= hunk_d;
    end
  end

  // summary for the end marker
  always_comb begin
    if (err_q != ST_OK) status_o = err_q;
    else if (phase_q == PH_HUNK) status_o = ST_OK;
    else if (phase_q == PH_HEADER) status_o = ST_NOT_HEADER;
    else status_o = ST_MALFORMED;
    segments_o      = '0;
    code_size_o     = '0;
    data_size_o     = '0;
    bss_size_o      = '0;
    reloc_entries_o = '0;
    symbol_count_o  = '0;
    debug_count_o   = '0;
    hunk_count_o    = '0;
    if (status_o == ST_OK) begin
      segments_o      = seg_q;
      code_size_o     = code_q;
      data_size_o     = data_q;
      bss_size_o      = bss_q;
      reloc_entries_o = reloc_q;
      symbol_count_o  = sym_q;
      debug_count_o   = dbg_q;
      hunk_count_o    = hunk_q;
    end
  end

`ifndef ASSERT_OFF
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK && !(fire && req_i.op == OP_EOF)) |=> err_q == $past(err_q))
    else $error("error code changed before end marker");

  a_eof_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && req_i.op == OP_EOF) |=> (phase_q == PH_HEADER && err_q == ST_OK
      && hunk_q == '0 && seg_q == '0))
    else $error("state not cleared after end marker");

  a_skip_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RESSKIP || phase_q == PH_BODYSKIP || phase_q == PH_RELTGT
      || phase_q == PH_RELSKIP || phase_q == PH_SYMSKIP) |-> skip_q != '0)
    else $error("skip phase with empty skip count");

  a_header_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> (hunk_q == '0 && code_q == '0 && reloc_q == '0))
    else $error("totals nonzero before header");
`endif

endmodule

`default_nettype wire

// ===== rtl/hesp_out_stage.sv =====
// ----------------------------------------------------------------------------
// hesp_out_stage
// result register holding one summary until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module hesp_out_stage import hesp_pkg::*; #(
  parameter int unsigned BYTE_COUNT_BITS  = BYTE_COUNT_BITS_DEF,
  parameter int unsigned EVENT_COUNT_BITS = EVENT_COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  status_e                     status_i,
  input  logic [EVENT_COUNT_BITS-1:0] segments_i,
  input  logic [BYTE_COUNT_BITS-1:0]  code_size_i,
  input  logic [BYTE_COUNT_BITS-1:0]  data_size_i,
  input  logic [BYTE_COUNT_BITS-1:0]  bss_size_i,
  input  logic [EVENT_COUNT_BITS-1:0] reloc_entries_i,
  input  logic [EVENT_COUNT_BITS-1:0] symbol_count_i,
  input  logic [EVENT_COUNT_BITS-1:0] debug_count_i,
  input  logic [EVENT_COUNT_BITS-1:0] hunk_count_i,
  output logic                        free_o,
  hesp_out_if.source                  out_o
);

  logic                        valid_q;
  logic [2:0]                  status_q;
  logic [EVENT_COUNT_BITS-1:0] seg_q;
  logic [BYTE_COUNT_BITS-1:0]  code_q;
  logic [BYTE_COUNT_BITS-1:0]  data_q;
  logic [BYTE_COUNT_BITS-1:0]  bss_q;
  logic [EVENT_COUNT_BITS-1:0] reloc_q;
  logic [EVENT_COUNT_BITS-1:0] sym_q;
  logic [EVENT_COUNT_BITS-1:0] dbg_q;
  logic [EVENT_COUNT_BITS-1:0] hunk_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      status_q <= status_i;
      seg_q    <= segments_i;
      code_q   <= code_size_i;
      data_q   <= data_size_i;
      bss_q    <= bss_size_i;
      reloc_q  <= reloc_entries_i;
      sym_q    <= symbol_count_i;
      dbg_q    <= debug_count_i;
      hunk_q   <= hunk_count_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.status        = status_q;
  assign out_o.segments      = seg_q;
  assign out_o.code_size     = code_q;
  assign out_o.data_size     = data_q;
  assign out_o.bss_size      = bss_q;
  assign out_o.reloc_entries = reloc_q;
  assign out_o.symbol_count  = sym_q;
  assign out_o.debug_count   = dbg_q;
  assign out_o.hunk_count    = hunk_q;

endmodule

`default_nettype wire

// ===== rtl/hunk_executable_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// hunk_executable_stream_parser_top
// parses a hunk executable word stream and reports one summary per file
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_i     in   valid / ready  op, word
//  out_o    out  valid / ready  status, segments, byte totals, event totals
//
//  one request per cycle, sustained while no end marker is held back; a word
//  goes through the input register and then the phase machine, and the
//  summary leaves from the result register
//  an end marker waits in the input register while the result register is
//  full and not taken; data words never wait on the output side
//  reset puts the parser in the header phase with all totals cleared
// ----------------------------------------------------------------------------
`default_nettype none

module hunk_executable_stream_parser_top import hesp_pkg::*; #(
  parameter int unsigned BYTE_COUNT_BITS  = BYTE_COUNT_BITS_DEF,
  parameter int unsigned EVENT_COUNT_BITS = EVENT_COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hesp_in_if.sink    in_i,
  hesp_out_if.source out_o
);

  hesp_req_t                   req;
  logic                        advance;
  logic                        load;
  logic                        out_free;
  status_e                     status;
  logic [EVENT_COUNT_BITS-1:0] segments;
  logic [BYTE_COUNT_BITS-1:0]  code_size;
  logic [BYTE_COUNT_BITS-1:0]  data_size;
  logic [BYTE_COUNT_BITS-1:0]  bss_size;
  logic [EVENT_COUNT_BITS-1:0] reloc_entries;
  logic [EVENT_COUNT_BITS-1:0] symbol_count;
  logic [EVENT_COUNT_BITS-1:0] debug_count;
  logic [EVENT_COUNT_BITS-1:0] hunk_count;

  hesp_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .req_o     (req)
  );

  hesp_core #(
    .BYTE_COUNT_BITS  (BYTE_COUNT_BITS),
    .EVENT_COUNT_BITS (EVENT_COUNT_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req),
    .out_free_i      (out_free),
    .advance_o       (advance),
    .load_o          (load),
    .status_o        (status),
    .segments_o      (segments),
    .code_size_o     (code_size),
    .data_size_o     (data_size),
    .bss_size_o      (bss_size),
    .reloc_entries_o (reloc_entries),
    .symbol_count_o  (symbol_count),
    .debug_count_o   (debug_count),
    .hunk_count_o    (hunk_count)
  );

  hesp_out_stage #(
    .BYTE_COUNT_BITS  (BYTE_COUNT_BITS),
    .EVENT_COUNT_BITS (EVENT_COUNT_BITS)
  ) u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .status_i        (status),
    .segments_i      (segments),
    .code_size_i     (code_size),
    .data_size_i     (data_size),
    .bss_size_i      (bss_size),
    .reloc_entries_i (reloc_entries),
    .symbol_count_i  (symbol_count),
    .debug_count_i   (debug_count),
    .hunk_count_i    (hunk_count),
    .free_o          (out_free),
    .out_o           (out_o)
  );

endmodule

`default_nettype wire
